[rtl/core/connection_string_parser_top_defines.svh]
// Assertion helpers for the parser RTL.
`ifndef CONNECTION_STRING_PARSER_TOP_DEFINES_SVH
`define CONNECTION_STRING_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CSP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/csp_pkg.sv]
package csp_pkg;

  localparam int KEY_MAX     = 12;
  localparam int KEY_LEN_W   = $clog2(KEY_MAX + 2);
  localparam int KEY_IDX_W   = $clog2(KEY_MAX);
  localparam int KW_TEXT_LEN = 11;
  localparam int NUM_FIELDS  = 6;

  localparam logic [15:0] DEFAULT_PORT_RST = 16'd3306;

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [1:0] EV_CHAR = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;

  localparam logic [2:0] ERR_UNKNOWN_KEY = 3'd0;
  localparam logic [2:0] ERR_ALREADY_SET = 3'd1;
  localparam logic [2:0] ERR_BAD_PORT    = 3'd2;
  localparam logic [2:0] ERR_BAD_FLAG    = 3'd3;
  localparam logic [2:0] ERR_INCOMPLETE  = 3'd4;

  localparam logic [2:0] FLD_APP    = 3'd0;
  localparam logic [2:0] FLD_HOST   = 3'd1;
  localparam logic [2:0] FLD_USER   = 3'd2;
  localparam logic [2:0] FLD_PASSWD = 3'd3;
  localparam logic [2:0] FLD_DB     = 3'd4;
  localparam logic [2:0] FLD_SOCKET = 3'd5;

  // Key text of the socket path field
  localparam logic [KW_TEXT_LEN*8-1:0] KW_SOCKET_TEXT = {"unix_", "socket"};

  // Key lookup targets: fields use their field id.
  localparam logic [3:0] TGT_PORT = 4'd6;
  localparam logic [3:0] TGT_FLAG = 4'd7;
  localparam logic [3:0] TGT_NONE = 4'd8;

  typedef enum logic [7:0] {
    M_KEY      = 8'b0000_0001,
    M_VAL      = 8'b0000_0010,
    M_VAL_ESC  = 8'b0000_0100,
    M_QVAL     = 8'b0000_1000,
    M_QVAL_ESC = 8'b0001_0000,
    M_PORT     = 8'b0010_0000,
    M_FLAG     = 8'b0100_0000,
    M_ERR      = 8'b1000_0000
  } mode_t;

  typedef logic [KEY_MAX-1:0][7:0] key_buf_t;

  typedef struct packed {
    mode_t                  mode;
    logic [KEY_LEN_W-1:0]   key_len;
    logic [2:0]             field;
    logic [NUM_FIELDS-1:0]  mask;
    logic                   quote_dq;
    logic [15:0]            port;
    logic [31:0]            flags;
  } state_t;

  typedef struct packed {
    logic [1:0]             ev;
    logic [2:0]             field_id;
    logic [7:0]             value;
    logic [15:0]            port;
    logic [31:0]            flags;
    logic [NUM_FIELDS-1:0]  set_mask;
    logic [2:0]             err;
  } result_t;

  typedef struct packed {
    logic                   we;
    logic [KEY_IDX_W-1:0]   idx;
    logic [7:0]             data;
  } key_wr_t;

  function automatic state_t restart_state(input logic [15:0] dport);
    state_t s;
    s          = '0;
    s.mode     = M_KEY;
    s.port     = dport;
    return s;
  endfunction

  // Text holds the keyword with its first character in the highest used byte.
  function automatic logic kw_match(input key_buf_t kbuf,
                                    input logic [KEY_LEN_W-1:0] len,
                                    input logic [KW_TEXT_LEN*8-1:0] text,
                                    input int n);
    logic m;
    m = (len == KEY_LEN_W'(n));
    for (int i = 0; i < KW_TEXT_LEN; i++) begin
      if (i < n && kbuf[i] != text[8*(n-1-i) +: 8]) begin
        m = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic logic [3:0] key_lookup(input key_buf_t kbuf,
                                            input logic [KEY_LEN_W-1:0] len);
    logic [3:0] t;
    t = TGT_NONE;
    if (kw_match(kbuf, len, 88'("port"), 4))        t = TGT_PORT;
    if (kw_match(kbuf, len, 88'("flags"), 5))       t = TGT_FLAG;
    if (kw_match(kbuf, len, 88'("app"), 3))         t = {1'b0, FLD_APP};
    if (kw_match(kbuf, len, 88'("host"), 4))        t = {1'b0, FLD_HOST};
    if (kw_match(kbuf, len, 88'("user"), 4))        t = {1'b0, FLD_USER};
    if (kw_match(kbuf, len, 88'("passwd"), 6))      t = {1'b0, FLD_PASSWD};
    if (kw_match(kbuf, len, 88'("password"), 8))    t = {1'b0, FLD_PASSWD};
    if (kw_match(kbuf, len, 88'("db"), 2))          t = {1'b0, FLD_DB};
    if (kw_match(kbuf, len, 88'("dbname"), 6))      t = {1'b0, FLD_DB};
    if (kw_match(kbuf, len, 88'("database"), 8))    t = {1'b0, FLD_DB};
    if (kw_match(kbuf, len, KW_SOCKET_TEXT, 11))    t = {1'b0, FLD_SOCKET};
    return t;
  endfunction

endpackage

[rtl/core/connection_string_parser_top.sv]
// An accepted input word is held in the input register; any result word it yields is
//   held in the result register. Throughput: one input word per cycle while results
//   drain; the registers decouple the sides; parser state updates once per word.
// Reset (rst, synchronous, active high): parser to key mode, both stages empty,
//   default port back to 3306; the key buffer is not cleared.
`include "connection_string_parser_top_defines.svh"

module connection_string_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  char_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_res,
  output logic [2:0]  field_id,
  output logic [7:0]  value_byte,
  output logic [15:0] port_number,
  output logic [31:0] client_flags,
  output logic [5:0]  set_fields,
  output logic [2:0]  error_code
);
  import csp_pkg::*;

  logic        in_full;
  logic        in_kind;
  logic [7:0]  in_char;
  logic [15:0] default_port;
  state_t      st;
  state_t      st_next;
  key_buf_t    kbuf;
  key_wr_t     kwr;
  logic        res_valid;
  result_t     res;
  result_t     out_res;
  logic        advance;

  // Step the parser when a word is held and the result slot is free or draining.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  csp_step u_step (
    .st           (st),
    .kbuf         (kbuf),
    .default_port (default_port),
    .kind         (in_kind),
    .ch           (in_char),
    .st_next      (st_next),
    .kwr          (kwr),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_kind <= kind;
      in_char <= char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_port <= DEFAULT_PORT_RST;
      st           <= restart_state(DEFAULT_PORT_RST);
    end else begin
      if (advance) begin
        st <= st_next;
      end
      // a register write reloads the running port
      if (cfg_wr_en) begin
        default_port <= cfg_wr_data;
        st.port      <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && kwr.we) begin
      kbuf[kwr.idx] <= kwr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign event_res    = out_res.ev;
  assign field_id     = out_res.field_id;
  assign value_byte   = out_res.value;
  assign port_number  = out_res.port;
  assign client_flags = out_res.flags;
  assign set_fields   = out_res.set_mask;
  assign error_code   = out_res.err;

  `CSP_ASSERT_IMPL(a_mode_onehot, 1'b1, $onehot(st.mode), "parser mode not one-hot")
  `CSP_ASSERT_IMPL(a_key_len_range, 1'b1, st.key_len <= KEY_LEN_W'(KEY_MAX + 1),
    "key length past limit")
  `CSP_ASSERT_NEXT(a_err_enters_err_mode, advance && res_valid && !in_kind && res.ev == EV_ERR,
    st.mode == M_ERR, "error word without error mode")
  `CSP_ASSERT_NEXT(a_end_restarts, advance && in_kind && !cfg_wr_en,
    st.mode == M_KEY && st.mask == '0 && st.key_len == '0, "end word did not restart")

endmodule

[rtl/core/csp_step.sv]
module csp_step (
  input  csp_pkg::state_t   st,
  input  csp_pkg::key_buf_t kbuf,
  input  logic [15:0]       default_port,
  input  logic              kind,
  input  logic [7:0]        ch,
  output csp_pkg::state_t   st_next,
  output csp_pkg::key_wr_t  kwr,
  output logic              res_valid,
  output csp_pkg::result_t  res
);
  import csp_pkg::*;

  logic        is_ws;
  logic        is_digit;
  logic [3:0]  digit;
  logic [3:0]  tgt;
  logic [19:0] port_mul;
  logic [15:0] port_sat;
  logic [31:0] flags_mul;

  assign is_ws    = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit    = ch[3:0];
  assign tgt      = key_lookup(kbuf, st.key_len);

  // port * 10 + digit, saturated to 16 bits
  assign port_mul  = {1'b0, st.port, 3'b000} + {3'b000, st.port, 1'b0} + {16'd0, digit};
  assign port_sat  = (port_mul[19:16] != 4'd0) ? 16'hFFFF : port_mul[15:0];
  // flags * 10 + digit, wraps
  assign flags_mul = {st.flags[28:0], 3'b000} + {st.flags[30:0], 1'b0} + {28'd0, digit};

  always_comb begin
    st_next   = st;
    kwr.we    = 1'b0;
    kwr.idx   = st.key_len[KEY_IDX_W-1:0];
    kwr.data  = ch;
    res_valid = 1'b0;
    res       = '0;

    if (kind) begin
      if (st.mode != M_ERR) begin
        res_valid = 1'b1;
        if (st.mode == M_KEY && st.key_len != '0) begin
          res.ev  = EV_ERR;
          res.err = ERR_INCOMPLETE;
        end else begin
          res.ev       = EV_DONE;
          res.port     = st.port;
          res.flags    = st.flags;
          res.set_mask = st.mask;
        end
      end
      st_next = restart_state(default_port);
    end else begin
      unique case (st.mode)
        M_KEY: begin
          if (ch == CH_EQ) begin
            st_next.key_len = '0;
            if (tgt == TGT_PORT) begin
              st_next.port = '0;
              st_next.mode = M_PORT;
            end else if (tgt == TGT_FLAG) begin
              st_next.mode = M_FLAG;
            end else if (tgt == TGT_NONE) begin
              st_next.mode = M_ERR;
              res_valid    = 1'b1;
              res.ev       = EV_ERR;
              res.err      = ERR_UNKNOWN_KEY;
            end else if (st.mask[tgt[2:0]]) begin
              st_next.mode = M_ERR;
              res_valid    = 1'b1;
              res.ev       = EV_ERR;
              res.err      = ERR_ALREADY_SET;
            end else begin
              st_next.field = tgt[2:0];
              st_next.mode  = M_VAL;
            end
          end else if (!(st.key_len == '0 && is_ws)) begin
            if (st.key_len < KEY_LEN_W'(KEY_MAX)) begin
              kwr.we = 1'b1;
            end
            // stop counting one past the limit so the key reads as unknown
            if (st.key_len <= KEY_LEN_W'(KEY_MAX)) begin
              st_next.key_len = st.key_len + 1'b1;
            end
          end
        end
        M_VAL: begin
          if (ch == CH_SEMI || is_ws) begin
            st_next.mode = M_KEY;
          end else if (ch == CH_BSLASH) begin
            st_next.mode = M_VAL_ESC;
          end else if (!st.mask[st.field] && (ch == CH_SQUOTE || ch == CH_DQUOTE)) begin
            st_next.quote_dq = (ch == CH_DQUOTE);
            st_next.mode     = M_QVAL;
          end else begin
            st_next.mask[st.field] = 1'b1;
            res_valid    = 1'b1;
            res.ev       = EV_CHAR;
            res.field_id = st.field;
            res.value    = ch;
          end
        end
        M_VAL_ESC, M_QVAL_ESC: begin
          st_next.mode = (st.mode == M_VAL_ESC) ? M_VAL : M_QVAL;
          st_next.mask[st.field] = 1'b1;
          res_valid    = 1'b1;
          res.ev       = EV_CHAR;
          res.field_id = st.field;
          res.value    = ch;
        end
        M_QVAL: begin
          if (ch == (st.quote_dq ? CH_DQUOTE : CH_SQUOTE)) begin
            st_next.mode = M_KEY;
          end else if (ch == CH_BSLASH) begin
            st_next.mode = M_QVAL_ESC;
          end else begin
            st_next.mask[st.field] = 1'b1;
            res_valid    = 1'b1;
            res.ev       = EV_CHAR;
            res.field_id = st.field;
            res.value    = ch;
          end
        end
        M_PORT: begin
          if (ch == CH_SEMI || is_ws) begin
            st_next.mode = M_KEY;
          end else if (is_digit) begin
            st_next.port = port_sat;
          end else begin
            st_next.mode = M_ERR;
            res_valid    = 1'b1;
            res.ev       = EV_ERR;
            res.err      = ERR_BAD_PORT;
          end
        end
        M_FLAG: begin
          if (ch == CH_SEMI || is_ws) begin
            st_next.mode = M_KEY;
          end else if (is_digit) begin
            st_next.flags = flags_mul;
          end else begin
            st_next.mode = M_ERR;
            res_valid    = 1'b1;
            res.ev       = EV_ERR;
            res.err      = ERR_BAD_FLAG;
          end
        end
        M_ERR: begin
          // drop everything until the end word
        end
        default: begin
          st_next.mode = M_ERR;
        end
      endcase
    end
  end

endmodule
